@@ sv/lgrv_pkg.sv @@
// Package for the log group replay validator: transaction payload types,
// status codes and default widths. Depends on nothing else.
package lgrv_pkg;

   localparam int GROUP_ID_BITS_DEF    = 32;
   localparam int PAGE_COUNT_BITS_DEF  = 31;
   localparam int ENTRY_COUNT_BITS_DEF = 40;

   localparam int PAGE_GROUP_W     = 32;
   localparam int PAGE_ENTRIES_W   = 16;
   localparam int DECLARED_W       = 31;
   localparam int REPLAY_PAGES_W   = 32;
   localparam int REPLAY_ENTRIES_W = 40;

   typedef enum logic [1:0] {
      ST_SCAN  = 2'd0,
      ST_GAP   = 2'd1,
      ST_SHORT = 2'd2,
      ST_DONE  = 2'd3
   } lgrv_status_type;

   typedef enum logic {
      OP_PAGE = 1'b0,
      OP_END  = 1'b1
   } lgrv_opcode_type;

   typedef struct packed {
      lgrv_opcode_type            opcode;
      logic                       page_valid;
      logic [PAGE_GROUP_W-1:0]    page_group;
      logic [PAGE_ENTRIES_W-1:0]  page_entries;
      logic [DECLARED_W-1:0]      declared_pages;
      logic                       ends_stream;
   } lgrv_req_type;

   typedef struct packed {
      logic [REPLAY_PAGES_W-1:0]   replay_pages;
      logic [REPLAY_ENTRIES_W-1:0] replay_entries;
      logic                        stream_done;
      lgrv_status_type             status;
   } lgrv_rsp_type;

endpackage

@@ sv/log_group_replay_validator_core.sv @@
// Top level of the log group replay validator: input register, state update
// and result registers. Depends on lgrv_pkg.
//
//  Channel  | Direction | Handshake              | Payload
//  req_     | in        | req_valid / req_ready  | req_data (lgrv_req_type)
//  rsp_     | out       | rsp_valid / rsp_ready  | rsp_data (lgrv_rsp_type)
//
// One transaction is accepted per cycle unless results stall; one result each.
// The state registers double as the result register, so an update happens only
// when the previous result has been taken or none is pending.
// A stalled result holds the input register; the input side then stalls too.
// Reset is synchronous and clears all control and scan state.
module log_group_replay_validator_core #(
   parameter int GROUP_ID_BITS    = lgrv_pkg::GROUP_ID_BITS_DEF,
   parameter int PAGE_COUNT_BITS  = lgrv_pkg::PAGE_COUNT_BITS_DEF,
   parameter int ENTRY_COUNT_BITS = lgrv_pkg::ENTRY_COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lgrv_pkg::lgrv_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lgrv_pkg::lgrv_rsp_type rsp_data
);
   import lgrv_pkg::*;

   logic                        in_valid_ff;
   lgrv_req_type                in_data_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        advance;

   logic                        run_open_ff, run_open_in;
   logic [GROUP_ID_BITS-1:0]    run_group_ff, run_group_in;
   logic [GROUP_ID_BITS-1:0]    next_group_ff, next_group_in;
   logic [PAGE_COUNT_BITS-1:0]  run_pages_ff, run_pages_in;
   logic [ENTRY_COUNT_BITS-1:0] run_entries_ff, run_entries_in;
   logic [PAGE_COUNT_BITS-1:0]  run_declared_ff, run_declared_in;
   logic                        run_ends_ff, run_ends_in;
   logic [REPLAY_PAGES_W-1:0]   total_pages_ff, total_pages_in;
   logic [ENTRY_COUNT_BITS-1:0] total_entries_ff, total_entries_in;
   logic                        complete_ff, complete_in;
   lgrv_status_type             status_ff, status_in;

   logic [63:0]                 grp_wide;
   logic [GROUP_ID_BITS-1:0]    grp;
   logic [PAGE_COUNT_BITS-1:0]  decl;
   logic                        intact;
   logic [REPLAY_PAGES_W:0]     tp_sum;
   logic [REPLAY_PAGES_W-1:0]   tp_sat;
   logic [ENTRY_COUNT_BITS:0]   te_sum;
   logic [ENTRY_COUNT_BITS-1:0] te_sat;
   logic [63:0]                 te_wide;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign grp_wide = 64'(in_data_ff.page_group);
   assign grp      = grp_wide[GROUP_ID_BITS-1:0];
   assign decl     = in_data_ff.declared_pages[PAGE_COUNT_BITS-1:0];
   assign intact   = (run_declared_ff != '0) && (run_pages_ff == run_declared_ff);

   assign tp_sum = {1'b0, total_pages_ff} + (REPLAY_PAGES_W+1)'(run_pages_ff);
   assign tp_sat = tp_sum[REPLAY_PAGES_W] ? '1 : tp_sum[REPLAY_PAGES_W-1:0];
   assign te_sum = {1'b0, total_entries_ff} + {1'b0, run_entries_ff};
   assign te_sat = te_sum[ENTRY_COUNT_BITS] ? '1 : te_sum[ENTRY_COUNT_BITS-1:0];

   always_comb begin
      logic                        proceed;
      logic [PAGE_COUNT_BITS-1:0]  pages_base;
      logic [ENTRY_COUNT_BITS-1:0] entries_base;
      logic [PAGE_COUNT_BITS:0]    pages_sum;
      logic [ENTRY_COUNT_BITS:0]   entries_sum;

      run_open_in      = run_open_ff;
      run_group_in     = run_group_ff;
      next_group_in    = next_group_ff;
      run_pages_in     = run_pages_ff;
      run_entries_in   = run_entries_ff;
      run_declared_in  = run_declared_ff;
      run_ends_in      = run_ends_ff;
      total_pages_in   = total_pages_ff;
      total_entries_in = total_entries_ff;
      complete_in      = complete_ff;
      status_in        = status_ff;
      proceed          = 1'b0;
      pages_base       = run_pages_ff;
      entries_base     = run_entries_ff;
      pages_sum        = '0;
      entries_sum      = '0;

      if (status_ff == ST_SCAN) begin
         if (in_data_ff.opcode == OP_END) begin
            if (run_open_ff && intact) begin
               total_pages_in   = tp_sat;
               total_entries_in = te_sat;
               complete_in      = run_ends_ff;
            end
            run_open_in = 1'b0;
            status_in   = ST_DONE;
         end else if (in_data_ff.page_valid) begin
            proceed = 1'b1;
            if (run_open_ff && (grp != run_group_ff)) begin
               if (intact) begin
                  total_pages_in   = tp_sat;
                  total_entries_in = te_sat;
                  complete_in      = run_ends_ff;
                  next_group_in    = run_group_ff + GROUP_ID_BITS'(1);
               end else begin
                  status_in = ST_SHORT;
                  proceed   = 1'b0;
               end
               run_open_in = 1'b0;
            end
            if (proceed && !run_open_in) begin
               if (grp != next_group_in) begin
                  status_in = ST_GAP;
                  proceed   = 1'b0;
               end else begin
                  run_open_in     = 1'b1;
                  run_group_in    = grp;
                  pages_base      = '0;
                  entries_base    = '0;
                  run_declared_in = '0;
                  run_ends_in     = 1'b0;
               end
            end
            if (proceed) begin
               pages_sum      = {1'b0, pages_base} + (PAGE_COUNT_BITS+1)'(1);
               entries_sum    = {1'b0, entries_base}
                                + (ENTRY_COUNT_BITS+1)'(in_data_ff.page_entries);
               run_pages_in   = pages_sum[PAGE_COUNT_BITS] ? '1
                                : pages_sum[PAGE_COUNT_BITS-1:0];
               run_entries_in = entries_sum[ENTRY_COUNT_BITS] ? '1
                                : entries_sum[ENTRY_COUNT_BITS-1:0];
               if ((in_data_ff.declared_pages != '0) || in_data_ff.ends_stream) begin
                  run_declared_in = decl;
                  run_ends_in     = in_data_ff.ends_stream;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         run_open_ff      <= 1'b0;
         run_group_ff     <= '0;
         next_group_ff    <= '0;
         run_pages_ff     <= '0;
         run_entries_ff   <= '0;
         run_declared_ff  <= '0;
         run_ends_ff      <= 1'b0;
         total_pages_ff   <= '0;
         total_entries_ff <= '0;
         complete_ff      <= 1'b0;
         status_ff        <= ST_SCAN;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            run_open_ff      <= run_open_in;
            run_group_ff     <= run_group_in;
            next_group_ff    <= next_group_in;
            run_pages_ff     <= run_pages_in;
            run_entries_ff   <= run_entries_in;
            run_declared_ff  <= run_declared_in;
            run_ends_ff      <= run_ends_in;
            total_pages_ff   <= total_pages_in;
            total_entries_ff <= total_entries_in;
            complete_ff      <= complete_in;
            status_ff        <= status_in;
         end
      end
   end

   assign te_wide   = 64'(total_entries_ff);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.replay_pages   = total_pages_ff;
      rsp_data.replay_entries = (|te_wide[63:REPLAY_ENTRIES_W]) ? '1
                                : te_wide[REPLAY_ENTRIES_W-1:0];
      rsp_data.stream_done    = complete_ff;
      rsp_data.status         = status_ff;
   end

endmodule

@@ sv/lgrv_checker.sv @@
// Port-level checker for the log group replay validator, bound to the top
// level. Depends on lgrv_pkg and log_group_replay_validator_core.
module lgrv_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input lgrv_pkg::lgrv_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lgrv_pkg::lgrv_rsp_type rsp_data
);
   import lgrv_pkg::*;

   logic         rsp_fire;
   logic         seen_ff;
   lgrv_rsp_type last_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_fire) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         last_ff <= rsp_data;
      end
   end

   // A result that is not taken stays offered with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // No result is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // Once the scan has broken or finished, every later result repeats the last one.
   a_terminal_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff && (last_ff.status != ST_SCAN) |-> rsp_data == last_ff)
      else $error("result changed after scan ended");

   // Replay totals never go down between results.
   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |-> (rsp_data.replay_pages >= last_ff.replay_pages)
                          && (rsp_data.replay_entries >= last_ff.replay_entries))
      else $error("replay totals decreased");

endmodule

bind log_group_replay_validator_core lgrv_checker u_lgrv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for log_group_replay_validator_core: drives page header and
// end-of-traversal transactions and predicts every status result from its own model.
// Depends on lgrv_pkg and the core RTL only.
module testbench;
   import lgrv_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 10;

   typedef enum int {
      END_CLEAN,
      END_UNCLOSED,
      END_SHORT,
      BREAK_GAP,
      BREAK_SHORT
   } stream_end_kind;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC,
      RX_LONG_STALL
   } rx_mode_kind;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   lgrv_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lgrv_rsp_type rsp_data;

   logic                        run_open      = 1'b0;
   logic [PAGE_GROUP_W-1:0]     run_group     = '0;
   logic [PAGE_GROUP_W-1:0]     next_group    = '0;
   logic [DECLARED_W-1:0]       run_pages     = '0;
   logic [REPLAY_ENTRIES_W-1:0] run_entries   = '0;
   logic [DECLARED_W-1:0]       run_declared  = '0;
   logic                        run_ends      = 1'b0;
   logic [REPLAY_PAGES_W-1:0]   total_pages   = '0;
   logic [REPLAY_ENTRIES_W-1:0] total_entries = '0;
   logic                        stream_flag   = 1'b0;
   lgrv_status_type             scan_state    = ST_SCAN;

   lgrv_rsp_type            replay_status_q[$];
   logic [PAGE_GROUP_W-1:0] next_page_group = '0;
   int                      error_count = 0;
   int                      items_sent  = 0;
   int                      burst_left  = 0;
   int                      idle_cycles = 0;

   log_group_replay_validator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic run_intact();
      return run_declared != '0 && run_pages == run_declared;
   endfunction

   function automatic void accept_run();
      logic [REPLAY_PAGES_W:0]   page_sum;
      logic [REPLAY_ENTRIES_W:0] entry_sum;
      page_sum = total_pages + run_pages;
      total_pages = page_sum[REPLAY_PAGES_W] ? '1 : page_sum[REPLAY_PAGES_W-1:0];
      entry_sum = total_entries + run_entries;
      total_entries = entry_sum[REPLAY_ENTRIES_W] ? '1 : entry_sum[REPLAY_ENTRIES_W-1:0];
      stream_flag = run_ends;
   endfunction

   function automatic void scan_page(lgrv_req_type item);
      logic [DECLARED_W:0]       count_sum;
      logic [REPLAY_ENTRIES_W:0] entry_sum;
      if (run_open && item.page_group != run_group) begin
         if (run_intact()) begin
            accept_run();
            next_group = run_group + 1'b1;
         end else begin
            scan_state = ST_SHORT;
         end
         run_open = 1'b0;
      end
      if (scan_state != ST_SCAN) return;
      if (!run_open) begin
         if (item.page_group != next_group) begin
            scan_state = ST_GAP;
            return;
         end
         run_open     = 1'b1;
         run_group    = item.page_group;
         run_pages    = '0;
         run_entries  = '0;
         run_declared = '0;
         run_ends     = 1'b0;
      end
      count_sum = run_pages + 1'b1;
      run_pages = count_sum[DECLARED_W] ? '1 : count_sum[DECLARED_W-1:0];
      entry_sum = run_entries + item.page_entries;
      run_entries = entry_sum[REPLAY_ENTRIES_W] ? '1 : entry_sum[REPLAY_ENTRIES_W-1:0];
      if (item.declared_pages != '0 || item.ends_stream) begin
         run_declared = item.declared_pages;
         run_ends     = item.ends_stream;
      end
   endfunction

   function automatic lgrv_rsp_type track_replay(lgrv_req_type item);
      lgrv_rsp_type result;
      if (scan_state == ST_SCAN) begin
         if (item.opcode == OP_END) begin
            if (run_open && run_intact()) accept_run();
            run_open   = 1'b0;
            scan_state = ST_DONE;
         end else if (item.page_valid) begin
            scan_page(item);
         end
      end
      result.replay_pages   = total_pages;
      result.replay_entries = total_entries;
      result.stream_done    = stream_flag;
      result.status         = scan_state;
      return result;
   endfunction

   function automatic lgrv_req_type page_item(logic [PAGE_GROUP_W-1:0] group,
                                              logic [PAGE_ENTRIES_W-1:0] entries,
                                              logic [DECLARED_W-1:0] declared,
                                              logic ends);
      lgrv_req_type item;
      item.opcode         = OP_PAGE;
      item.page_valid     = 1'b1;
      item.page_group     = group;
      item.page_entries   = entries;
      item.declared_pages = declared;
      item.ends_stream    = ends;
      return item;
   endfunction

   function automatic lgrv_req_type skipped_page();
      lgrv_req_type item;
      item = page_item(PAGE_GROUP_W'($urandom), PAGE_ENTRIES_W'($urandom),
                       DECLARED_W'($urandom), 1'($urandom));
      item.page_valid = 1'b0;
      return item;
   endfunction

   function automatic lgrv_req_type end_item();
      lgrv_req_type item;
      item = skipped_page();
      item.opcode     = OP_END;
      item.page_valid = 1'($urandom);
      return item;
   endfunction

   function automatic logic [PAGE_ENTRIES_W-1:0] pick_entries();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PAGE_ENTRIES_W'($urandom);
      endcase
   endfunction

   function automatic int random_group_size();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
   endfunction

   task automatic send_item(input lgrv_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      replay_status_q.push_back(track_replay(item));
      items_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 50);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (replay_status_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_group(input int pages, input logic ends);
      int           closing_at;
      lgrv_req_type item;
      closing_at = $urandom_range(0, 1) ? pages - 1 : $urandom_range(0, pages - 1);
      for (int i = 0; i < pages; i++) begin
         if ($urandom_range(0, 5) == 0) send_item(skipped_page());
         item = page_item(next_page_group, pick_entries(), '0, 1'b0);
         if (i == closing_at) begin
            item.declared_pages = DECLARED_W'(pages);
            item.ends_stream    = ends;
         end else if (i < closing_at && $urandom_range(0, 3) == 0) begin
            item.declared_pages = DECLARED_W'($urandom);
            item.ends_stream    = 1'($urandom);
         end
         send_item(item);
      end
      next_page_group++;
   endtask

   task automatic test_directed_groups();
      lgrv_req_type item;
      send_item(page_item(0, '1, 1, 1'b1));
      item = '1;
      item.opcode     = OP_PAGE;
      item.page_valid = 1'b0;
      send_item(item);
      item = '0;
      item.page_group = 7;
      send_item(item);
      send_item(page_item(1, '0, '1, 1'b1));
      send_item(page_item(1, '1, '0, 1'b0));
      send_item(page_item(1, 16'h1234, 3, 1'b0));
      send_item(page_item(2, '0, 2, 1'b0));
      send_item(page_item(2, '1, '0, 1'b0));
      send_item(page_item(3, 1, '0, 1'b1));
      send_item(page_item(3, 2, 2, 1'b1));
      send_item(page_item(4, '1, 1, 1'b0));
      next_page_group = 5;
      wait_for_results();
   endtask

   task automatic test_random_stream();
      int start_count;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         send_group(random_group_size(), $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 59) == 0) wait_for_results();
      end
   endtask

   task automatic test_stream_end();
      stream_end_kind kind;
      int             pages;
      lgrv_req_type   item;
      kind  = stream_end_kind'($urandom_range(0, 4));
      pages = random_group_size();
      case (kind)
         END_CLEAN: begin
            send_group(pages, 1'($urandom));
            send_item(end_item());
         end
         END_UNCLOSED, END_SHORT: begin
            for (int i = 0; i < pages; i++) begin
               item = page_item(next_page_group, pick_entries(), '0, 1'b0);
               if (kind == END_SHORT && i == pages - 1) begin
                  item.declared_pages = DECLARED_W'(pages + $urandom_range(1, 100));
                  item.ends_stream    = 1'($urandom);
               end
               send_item(item);
            end
            send_item(end_item());
         end
         BREAK_GAP: begin
            item = page_item(next_page_group ^ (32'd1 << $urandom_range(0, 31)),
                             pick_entries(), DECLARED_W'($urandom), 1'($urandom));
            send_item(item);
         end
         default: begin
            for (int i = 0; i < pages; i++) begin
               item = page_item(next_page_group, pick_entries(), '0, 1'b0);
               if (i == pages - 1) begin
                  case ($urandom_range(0, 2))
                     0: item.declared_pages = '0;
                     1: item.declared_pages = DECLARED_W'(pages - 1);
                     default: item.declared_pages = DECLARED_W'(pages + 1);
                  endcase
                  item.ends_stream = 1'($urandom);
               end
               send_item(item);
            end
            send_item(page_item(next_page_group + 1'b1, pick_entries(), 1, 1'b0));
         end
      endcase
      wait_for_results();
   endtask

   task automatic test_after_stream_end();
      lgrv_req_type item;
      repeat (16) begin
         item = page_item(next_page_group - 1'b1 + $urandom_range(0, 2), pick_entries(),
                          DECLARED_W'($urandom_range(0, 3)), 1'($urandom));
         item.opcode     = lgrv_opcode_type'($urandom_range(0, 1));
         item.page_valid = 1'($urandom);
         send_item(item);
      end
      wait_for_results();
   endtask

   initial begin
      rx_mode_kind mode;
      int          span;
      int          period;
      forever begin
         mode   = rx_mode_kind'($urandom_range(0, 3));
         span   = $urandom_range(20, 300);
         period = $urandom_range(2, 5);
         for (int c = 0; c < span; c++) begin
            @(negedge clock);
            case (mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_ready <= (c % period) != 0;
               default:     rsp_ready <= (c % 24) >= 16;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      lgrv_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replay_status_q.size() == 0) begin
            $error("Result transaction arrived with no request outstanding.");
            error_count++;
         end else begin
            want = replay_status_q.pop_front();
            if (rsp_data.replay_pages !== want.replay_pages) begin
               $error("replay_pages: expected %0d, got %0d",
                      want.replay_pages, rsp_data.replay_pages);
               error_count++;
            end
            if (rsp_data.replay_entries !== want.replay_entries) begin
               $error("replay_entries: expected %0d, got %0d",
                      want.replay_entries, rsp_data.replay_entries);
               error_count++;
            end
            if (rsp_data.stream_done !== want.stream_done) begin
               $error("stream_done: expected %0d, got %0d",
                      want.stream_done, rsp_data.stream_done);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed_groups();
      test_random_stream();
      test_stream_end();
      test_after_stream_end();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && replay_status_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
